// ----- design/ldle_pkg.sv -----
// ----------------------------------------------------------------------------
// ldle_pkg
// Shared types, codes and helpers of the lossy delay link emulator.
// ----------------------------------------------------------------------------
package ldle_pkg;

    // Operation codes of a request
    localparam logic [2:0] OP_SEND     = 3'd0;
    localparam logic [2:0] OP_POLL     = 3'd1;
    localparam logic [2:0] OP_ADV_SND  = 3'd2;
    localparam logic [2:0] OP_ADV_RCV  = 3'd3;
    localparam logic [2:0] OP_CLOSE_SND = 3'd4;
    localparam logic [2:0] OP_CLOSE_RCV = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOSS    = 2'd0;
    localparam logic [1:0] CFG_LATENCY = 2'd1;
    localparam logic [1:0] CFG_JITTER  = 2'd2;
    localparam logic [1:0] CFG_SEED    = 2'd3;

    localparam logic [6:0]  PCT_MAX  = 7'd100;
    localparam logic [7:0]  LOSS_MOD = 8'd100;

    // One stored packet
    typedef struct packed {
        logic [63:0] time_ms;
        logic [63:0] order;
        logic [15:0] tag;
    } t_entry;

    // Result of one queue scan
    typedef struct packed {
        logic        free_found;
        logic        best_found;
        logic [63:0] best_time;
        logic [15:0] best_tag;
    } t_scan_res;

    // xorshift64 step (13, 7, 17)
    function automatic logic [63:0] rng_next(input logic [63:0] s);
        logic [63:0] a;
        logic [63:0] b;
        a = s ^ (s << 13);
        b = a ^ (a >> 7);
        return b ^ (b << 17);
    endfunction

endpackage

// ----- design/ldle_mod.sv -----
// ----------------------------------------------------------------------------
// ldle_mod
// Bit-serial remainder unit: 64-bit dividend by a 17-bit divisor, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module ldle_mod import ldle_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_done,
    output logic [16:0] o_rem
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [16:0] r_dsr;
    logic [17:0] r_rem;
    logic        r_done;
    logic [17:0] n_shift;
    logic [17:0] n_rem;

    // restoring step
    always_comb begin
        n_shift = {r_rem[16:0], r_dvd[63]};
        if (n_shift >= {1'b0, r_dsr}) begin
            n_rem = n_shift - {1'b0, r_dsr};
        end else begin
            n_rem = n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[16:0];

endmodule

// ----- design/ldle_queue.sv -----
// ----------------------------------------------------------------------------
// ldle_queue
// Delay queue: entry memory with registered read, valid flags, and a
// sequential scan that finds the first free slot and the earliest entry.
// ----------------------------------------------------------------------------
module ldle_queue import ldle_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_scan_start,
    output logic                           o_scan_done,
    output t_scan_res                      o_res,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_free_idx,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_best_idx,
    input  logic                           i_wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wr_idx,
    input  t_entry                         i_wr_entry,
    input  logic                           i_clr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_clr_idx
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    t_entry                 r_mem [QUEUE_DEPTH];
    t_entry                 r_rd;
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic                   r_scan_on;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_chk;
    logic                   r_chk_last;
    logic [IDX_W-1:0]       r_chk_idx;
    logic                   r_done;
    t_scan_res              r_res;
    logic [63:0]            r_best_order;
    logic [IDX_W-1:0]       r_free_idx;
    logic [IDX_W-1:0]       r_best_idx;
    logic                   n_less;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        r_rd <= r_mem[r_idx];
    end

    // key compare of the entry just read against the best so far
    assign n_less = (r_rd.time_ms < r_res.best_time) ||
                    ((r_rd.time_ms == r_res.best_time) && (r_rd.order < r_best_order));

    // valid flags and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_scan_on  <= 1'b0;
            r_idx      <= '0;
            r_chk      <= 1'b0;
            r_chk_last <= 1'b0;
            r_done     <= 1'b0;
            r_res      <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_clr_en) begin
                r_valid[i_clr_idx] <= 1'b0;
            end
            // issue reads
            r_chk      <= r_scan_on;
            r_chk_idx  <= r_idx;
            r_chk_last <= r_scan_on && (r_idx == LAST_IDX);
            if (i_scan_start) begin
                r_scan_on <= 1'b1;
                r_idx     <= '0;
                r_res     <= '0;
            end else if (r_scan_on) begin
                if (r_idx == LAST_IDX) begin
                    r_scan_on <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            // evaluate returned data
            if (r_chk) begin
                if (!r_valid[r_chk_idx]) begin
                    if (!r_res.free_found) begin
                        r_res.free_found <= 1'b1;
                        r_free_idx       <= r_chk_idx;
                    end
                end else if (!r_res.best_found || n_less) begin
                    r_res.best_found <= 1'b1;
                    r_res.best_time  <= r_rd.time_ms;
                    r_res.best_tag   <= r_rd.tag;
                    r_best_order     <= r_rd.order;
                    r_best_idx       <= r_chk_idx;
                end
                r_done <= r_chk_last;
            end
        end
    end

    assign o_scan_done = r_done;
    assign o_res       = r_res;
    assign o_free_idx  = r_free_idx;
    assign o_best_idx  = r_best_idx;

endmodule

// ----- design/lossy_delay_link_emulator.sv -----
// ----------------------------------------------------------------------------
// lossy_delay_link_emulator
// One direction of a lossy, delaying packet link with a timed delay queue.
// ----------------------------------------------------------------------------
// One request is handled at a time. Advance, close, unused codes and sends
// on a closed end go straight to the output stage. A poll runs the scan of
// the queue memory, one entry per cycle. A lost send waits on the 4-stage
// mod-100 pipeline of the loss draw. A send that survives passes the loss
// stage, the bit-serial remainder unit for the jitter draw, then the
// free-slot scan.
// A result waits in an output register, so a stalled receiver holds the
// next request only once a second result is ready.
module lossy_delay_link_emulator import ldle_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_packet_tag,
    input  logic [63:0] i_time_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic        o_lost,
    output logic        o_overflow,
    output logic [15:0] o_out_tag
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    // mod-100 folding: 2^16, 2^32, 2^48 mod 100, then reciprocal of 100
    localparam logic [23:0] FOLD_K16   = 24'd36;
    localparam logic [23:0] FOLD_K32   = 24'd96;
    localparam logic [23:0] FOLD_K48   = 24'd56;
    localparam logic [16:0] FOLD2_K    = 17'd36;
    localparam logic [32:0] RECIP_K    = 33'd41943; // floor(2^22 / 100)
    localparam logic [16:0] MOD_K      = 17'd100;
    localparam logic [2:0]  LSTEP_LAST = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_LOSS, S_JIT, S_SCAN, S_FINISH, S_OUT
    } t_state;

    t_state      r_state;
    logic [6:0]  r_loss;
    logic [15:0] r_lat;
    logic [15:0] r_jit;
    logic [63:0] r_rng;
    logic [63:0] r_snd_now;
    logic [63:0] r_rcv_now;
    logic [63:0] r_order;
    logic        r_snd_open;
    logic        r_rcv_open;
    logic        r_is_send;
    logic [15:0] r_tag;
    logic [17:0] r_delay;
    logic        r_res_ok;
    logic        r_res_lost;
    logic        r_res_ovf;
    logic [15:0] r_res_tag;
    logic        r_out_valid;
    logic        r_out_ok;
    logic        r_out_lost;
    logic        r_out_ovf;
    logic [15:0] r_out_tag;
    logic [2:0]  r_lstep;
    logic [23:0] r_f1;
    logic [16:0] r_f2;
    logic [10:0] r_q;
    logic [7:0]  r_lr;

    logic        div_start;
    logic [63:0] div_dvd;
    logic [16:0] div_dsr;
    logic        div_done;
    logic [16:0] div_rem;
    logic        scan_start;
    logic        scan_done;
    t_scan_res   scan_res;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] best_idx;
    logic        wr_en;
    logic        clr_en;
    t_entry      wr_entry;
    logic [6:0]  pct;
    logic [63:0] n_rng;
    logic signed [18:0] n_d;
    logic        in_acc;
    logic        out_acc;
    logic        poll_hit;
    logic [23:0] n_f1;
    logic [16:0] n_f2;
    logic [32:0] n_prod;
    logic [16:0] n_lr;
    logic [7:0]  n_lrem;
    logic        loss_hit;
    logic        draw_en;

    assign n_rng   = rng_next(r_rng);
    assign pct     = (r_loss > PCT_MAX) ? PCT_MAX : r_loss;
    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = r_out_valid && i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // loss draw mod 100: fold 16-bit chunks, then reciprocal with one fix-up
    assign n_f1 = {8'd0, r_rng[15:0]} + ({8'd0, r_rng[31:16]} * FOLD_K16)
                + ({8'd0, r_rng[47:32]} * FOLD_K32) + ({8'd0, r_rng[63:48]} * FOLD_K48);
    assign n_f2   = {1'b0, r_f1[15:0]} + ({9'd0, r_f1[23:16]} * FOLD2_K);
    assign n_prod = {16'd0, r_f2} * RECIP_K;
    assign n_lr   = r_f2 - ({6'd0, r_q} * MOD_K);
    assign n_lrem = (r_lr >= LOSS_MOD) ? (r_lr - LOSS_MOD) : r_lr;
    assign loss_hit = (n_lrem < {1'b0, pct});

    // mod-100 pipeline, settles within the loss stage
    always_ff @(posedge i_clk) begin
        r_f1 <= n_f1;
        r_f2 <= n_f2;
        r_q  <= n_prod[32:22];
        r_lr <= n_lr[7:0];
    end

    // jitter sample plus latency, clamped at zero later
    assign n_d = $signed({2'b00, div_rem}) + $signed({3'b000, r_lat})
               - $signed({3'b000, r_jit});

    // generator draws, divider and scan kick-off
    assign div_start  = (r_state == S_LOSS) && (r_lstep == LSTEP_LAST) && !loss_hit;
    assign draw_en    = (in_acc && (i_opcode == OP_SEND) && r_snd_open && r_rcv_open) ||
                        div_start;
    assign div_dvd    = n_rng;
    assign div_dsr    = {r_jit, 1'b1};
    assign scan_start = (in_acc && (i_opcode == OP_POLL)) ||
                        ((r_state == S_JIT) && div_done);

    // queue updates at the end of a send or poll
    assign poll_hit = scan_res.best_found && (scan_res.best_time <= r_rcv_now);
    assign wr_en    = (r_state == S_FINISH) && r_is_send && scan_res.free_found;
    assign clr_en   = (r_state == S_FINISH) && !r_is_send && poll_hit;
    assign wr_entry = '{time_ms: r_snd_now + {46'd0, r_delay}, order: r_order, tag: r_tag};

    ldle_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    ldle_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan_start (scan_start),
        .o_scan_done  (scan_done),
        .o_res        (scan_res),
        .o_free_idx   (free_idx),
        .o_best_idx   (best_idx),
        .i_wr_en      (wr_en),
        .i_wr_idx     (free_idx),
        .i_wr_entry   (wr_entry),
        .i_clr_en     (clr_en),
        .i_clr_idx    (best_idx)
    );

    // control FSM, link state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loss      <= '0;
            r_lat       <= '0;
            r_jit       <= '0;
            r_rng       <= 64'd1;
            r_snd_now   <= '0;
            r_rcv_now   <= '0;
            r_order     <= '0;
            r_snd_open  <= 1'b1;
            r_rcv_open  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (out_acc && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    CFG_LOSS:    r_loss <= i_cfg_data[6:0];
                    CFG_LATENCY: r_lat  <= i_cfg_data[15:0];
                    CFG_JITTER:  r_jit  <= i_cfg_data[15:0];
                    CFG_SEED:    r_rng  <= (i_cfg_data == 64'd0) ? 64'd1 : i_cfg_data;
                    default:     ;
                endcase
            end else if (draw_en) begin
                r_rng <= n_rng;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_ok   <= 1'b0;
                        r_res_lost <= 1'b0;
                        r_res_ovf  <= 1'b0;
                        r_res_tag  <= '0;
                        r_tag      <= i_packet_tag;
                        r_is_send  <= (i_opcode == OP_SEND);
                        r_state    <= S_OUT;
                        unique case (i_opcode)
                            OP_SEND: begin
                                if (r_snd_open && r_rcv_open) begin
                                    r_res_ok <= 1'b1;
                                    r_lstep  <= '0;
                                    r_state  <= S_LOSS;
                                end
                            end
                            OP_POLL:      r_state <= S_SCAN;
                            OP_ADV_SND:   if (i_time_ms > r_snd_now) r_snd_now <= i_time_ms;
                            OP_ADV_RCV:   if (i_time_ms > r_rcv_now) r_rcv_now <= i_time_ms;
                            OP_CLOSE_SND: r_snd_open <= 1'b0;
                            OP_CLOSE_RCV: r_rcv_open <= 1'b0;
                            default:      ;
                        endcase
                    end
                end
                S_LOSS: begin
                    r_lstep <= r_lstep + 3'd1;
                    if (r_lstep == LSTEP_LAST) begin
                        if (loss_hit) begin
                            r_res_lost <= 1'b1;
                            r_state    <= S_OUT;
                        end else begin
                            r_state <= S_JIT;
                        end
                    end
                end
                S_JIT: begin
                    if (div_done) begin
                        r_delay <= n_d[18] ? 18'd0 : n_d[17:0];
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (r_is_send) begin
                        if (scan_res.free_found) begin
                            r_order <= r_order + 64'd1;
                        end else begin
                            r_res_ovf <= 1'b1;
                        end
                    end else if (poll_hit) begin
                        r_res_ok  <= 1'b1;
                        r_res_tag <= scan_res.best_tag;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_res_ok;
                        r_out_lost  <= r_res_lost;
                        r_out_ovf   <= r_res_ovf;
                        r_out_tag   <= r_res_tag;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_out_ok;
    assign o_lost      = r_out_lost;
    assign o_overflow  = r_out_ovf;
    assign o_out_tag   = r_out_tag;

    // a drop flag always comes with an accepted send
    a_drop_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_lost || o_overflow)) |-> o_ok)
        else $error("drop flag without ok");

    // lost and overflow never both set
    a_drop_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_lost && o_overflow))
        else $error("lost and overflow together");

    // a delivered tag only on a successful poll
    a_tag_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (!o_ok || o_lost || o_overflow)) |-> (o_out_tag == 16'd0))
        else $error("tag without delivery");

    // queue write and clear never coincide
    a_wr_clr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && clr_en))
        else $error("write and clear in one cycle");

endmodule
